// ----- rtl/cps_pkg.sv -----
package cps_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        CLAMP_INTERIOR = 2'd0,
        CLAMP_START    = 2'd1,
        CLAMP_END      = 2'd2
    } t_clamp;

endpackage

// ----- rtl/closest_point_on_segment.sv -----
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_ax i_ay i_az i_bx i_by i_bz i_px i_py i_pz
// output  | o_valid | i_stall | o_qx o_qy o_qz o_clamp_case
//
// one item per cycle while the output is not stalled; the restoring divider
// retires one quotient bit per stage
// reset is synchronous and clears the valid bits only
// the whole pipeline holds while the output item is valid and stalled,
// so o_stall follows i_stall when the output register is full
module closest_point_on_segment import cps_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_az,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_bz,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_pz,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [COORD_WIDTH-1:0] o_qx,
    output logic signed [COORD_WIDTH-1:0] o_qy,
    output logic signed [COORD_WIDTH-1:0] o_qz,
    output logic [1:0]                    o_clamp_case
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;          // differences
    localparam int PW = 2 * DW;         // products of differences
    localparam int SW = PW + 2;         // dot product, signed
    localparam int LW = PW;             // squared length, unsigned
    localparam int NW = DW + LW;        // numerator |d| * s

    // pipeline advances unless the output item is held
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    logic signed [W-1:0] in_a [3];
    logic signed [W-1:0] in_b [3];
    logic signed [W-1:0] in_p [3];
    assign in_a = '{i_ax, i_ay, i_az};
    assign in_b = '{i_bx, i_by, i_bz};
    assign in_p = '{i_px, i_py, i_pz};

    // stage 1: differences d = b - a, e = p - a
    logic                 r1_vld;
    logic signed [W-1:0]  r1_a [3];
    logic signed [W-1:0]  r1_b [3];
    logic signed [DW-1:0] r1_d [3];
    logic signed [DW-1:0] r1_e [3];

    // stage 2: products
    logic                 r2_vld;
    logic signed [W-1:0]  r2_a [3];
    logic signed [W-1:0]  r2_b [3];
    logic signed [DW-1:0] r2_d [3];
    logic signed [PW-1:0] r2_pe [3];
    logic signed [PW-1:0] r2_pd [3];

    // stage 3: dot product and squared length
    logic                 r3_vld;
    logic signed [W-1:0]  r3_a [3];
    logic signed [W-1:0]  r3_b [3];
    logic signed [DW-1:0] r3_d [3];
    logic signed [SW-1:0] r3_s;
    logic [LW-1:0]        r3_l;

    // stage 4: classify, magnitudes, split s into halves
    logic                 r4_vld;
    logic signed [W-1:0]  r4_a [3];
    logic signed [W-1:0]  r4_b [3];
    t_clamp               r4_case;
    logic [DW-1:0]        r4_mag [3];
    logic [2:0]           r4_neg;
    logic [DW-1:0]        r4_slo;
    logic [LW-DW-1:0]     r4_shi;
    logic [LW-1:0]        r4_l;

    // stage 5: partial products
    logic                 r5_vld;
    logic signed [W-1:0]  r5_a [3];
    logic signed [W-1:0]  r5_b [3];
    t_clamp               r5_case;
    logic [2:0]           r5_neg;
    logic [PW-1:0]        r5_plo [3];
    logic [PW-1:0]        r5_phi [3];
    logic [LW-1:0]        r5_l;

    // divider stages: index 0 holds the combined numerator
    logic                 r_dv_vld  [W+1];
    logic signed [W-1:0]  r_dv_a    [W+1][3];
    logic signed [W-1:0]  r_dv_b    [W+1][3];
    t_clamp               r_dv_case [W+1];
    logic [2:0]           r_dv_neg  [W+1];
    logic [LW-1:0]        r_dv_l    [W+1];
    logic [NW-1:0]        r_dv_rem  [W+1][3];
    logic [W-1:0]         r_dv_q    [W+1][3];

    logic [DW-1:0] n4_mag [3];
    t_clamp        n4_case;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n4_mag[k] = r3_d[k][DW-1] ? DW'(-r3_d[k]) : DW'(r3_d[k]);
        end
        if (r3_s <= 0) begin
            n4_case = CLAMP_START;
        end else if (r3_s[LW-1:0] >= r3_l) begin
            n4_case = CLAMP_END;
        end else begin
            n4_case = CLAMP_INTERIOR;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            for (int j = 0; j <= W; j++) begin
                r_dv_vld[j] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (en) begin
            r1_vld      <= i_valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r5_vld      <= r4_vld;
            r_dv_vld[0] <= r5_vld;
            for (int j = 0; j < W; j++) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
            o_valid <= r_dv_vld[W];
        end
    end

    // front stages payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_a[k]  <= in_a[k];
                r1_b[k]  <= in_b[k];
                r1_d[k]  <= DW'(in_b[k]) - DW'(in_a[k]);
                r1_e[k]  <= DW'(in_p[k]) - DW'(in_a[k]);

                r2_a[k]  <= r1_a[k];
                r2_b[k]  <= r1_b[k];
                r2_d[k]  <= r1_d[k];
                r2_pe[k] <= PW'(r1_e[k]) * PW'(r1_d[k]);
                r2_pd[k] <= PW'(r1_d[k]) * PW'(r1_d[k]);

                r3_a[k]  <= r2_a[k];
                r3_b[k]  <= r2_b[k];
                r3_d[k]  <= r2_d[k];

                r4_a[k]   <= r3_a[k];
                r4_b[k]   <= r3_b[k];
                r4_mag[k] <= n4_mag[k];
                r4_neg[k] <= r3_d[k][DW-1];

                r5_a[k]   <= r4_a[k];
                r5_b[k]   <= r4_b[k];
                r5_plo[k] <= PW'(r4_mag[k]) * PW'(r4_slo);
                r5_phi[k] <= PW'(r4_mag[k]) * PW'(r4_shi);
            end
            r3_s    <= SW'(r2_pe[0]) + SW'(r2_pe[1]) + SW'(r2_pe[2]);
            r3_l    <= LW'(r2_pd[0]) + LW'(r2_pd[1]) + LW'(r2_pd[2]);

            r4_case <= n4_case;
            r4_slo  <= r3_s[DW-1:0];
            r4_shi  <= r3_s[LW-1:DW];
            r4_l    <= r3_l;

            r5_case <= r4_case;
            r5_neg  <= r4_neg;
            r5_l    <= r4_l;
        end
    end

    // divisor aligned to the quotient bit of each stage
    logic [NW-1:0] dvs [W];

    always_comb begin
        for (int j = 0; j < W; j++) begin
            dvs[j] = NW'(r_dv_l[j]) << (W - 1 - j);
        end
    end

    // restoring divider, quotient bit W-1-j decided in stage j
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_dv_a[0][k]   <= r5_a[k];
                r_dv_b[0][k]   <= r5_b[k];
                r_dv_rem[0][k] <= NW'(r5_plo[k]) + (NW'(r5_phi[k]) << DW);
                r_dv_q[0][k]   <= '0;
            end
            r_dv_case[0] <= r5_case;
            r_dv_neg[0]  <= r5_neg;
            r_dv_l[0]    <= r5_l;

            for (int j = 0; j < W; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_dv_a[j+1][k] <= r_dv_a[j][k];
                    r_dv_b[j+1][k] <= r_dv_b[j][k];
                    if (r_dv_rem[j][k] >= dvs[j]) begin
                        r_dv_rem[j+1][k] <= r_dv_rem[j][k] - dvs[j];
                        r_dv_q[j+1][k]   <= r_dv_q[j][k] | (W'(1) << (W - 1 - j));
                    end else begin
                        r_dv_rem[j+1][k] <= r_dv_rem[j][k];
                        r_dv_q[j+1][k]   <= r_dv_q[j][k];
                    end
                end
                r_dv_case[j+1] <= r_dv_case[j];
                r_dv_neg[j+1]  <= r_dv_neg[j];
                r_dv_l[j+1]    <= r_dv_l[j];
            end
        end
    end

    // output stage: apply sign of d, add to a, select by case
    logic signed [W-1:0] n_q [3];
    logic signed [DW-1:0] off [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            off[k] = r_dv_neg[W][k] ? -DW'(r_dv_q[W][k]) : DW'(r_dv_q[W][k]);
            unique case (r_dv_case[W])
                CLAMP_START: n_q[k] = r_dv_a[W][k];
                CLAMP_END:   n_q[k] = r_dv_b[W][k];
                default:     n_q[k] = W'(DW'(r_dv_a[W][k]) + off[k]);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_qx         <= n_q[0];
            o_qy         <= n_q[1];
            o_qz         <= n_q[2];
            o_clamp_case <= r_dv_case[W];
        end
    end

endmodule

// ----- tb/cps_checker.sv -----
module cps_checker import cps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] ax, ay, az, bx, by, bz, px, py, pz,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] qx, qy, qz,
    input  logic [1:0]         clamp_case,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        t_clamp             cc;
    } t_point;

    t_point nearest_q[$];

    // exact projection, 200-bit signed is ample for 33x33x2 + 70-bit products
    function automatic t_point nearest_point(
        logic signed [31:0] ax, ay, az, bx, by, bz, px, py, pz);
        logic signed [199:0] a [3];
        logic signed [199:0] d [3];
        logic signed [199:0] p [3];
        logic signed [199:0] s, len, off, mag;
        logic signed [31:0] q [3];
        t_point r;
        a[0] = ax; a[1] = ay; a[2] = az;
        p[0] = px; p[1] = py; p[2] = pz;
        d[0] = 200'(bx) - a[0];
        d[1] = 200'(by) - a[1];
        d[2] = 200'(bz) - a[2];
        s = 0;
        len = 0;
        for (int k = 0; k < 3; k++) begin
            s += (p[k] - a[k]) * d[k];
            len += d[k] * d[k];
        end
        if (s <= 0 || len == 0) begin
            r.x = ax; r.y = ay; r.z = az; r.cc = CLAMP_START;
        end else if (s >= len) begin
            r.x = bx; r.y = by; r.z = bz; r.cc = CLAMP_END;
        end else begin
            for (int k = 0; k < 3; k++) begin
                mag = (d[k] < 0) ? -d[k] : d[k];
                off = (mag * s) / len;
                if (d[k] < 0) off = -off;
                q[k] = 32'(a[k] + off);
            end
            r.x = q[0]; r.y = q[1]; r.z = q[2]; r.cc = CLAMP_INTERIOR;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (in_valid && !in_stall)
                nearest_q.push_back(nearest_point(ax, ay, az, bx, by, bz, px, py, pz));
            if (out_valid && !out_stall) begin
                if (nearest_q.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count <= fail_count + 1;
                end else begin
                    e = nearest_q.pop_front();
                    if (qx !== e.x || qy !== e.y || qz !== e.z ||
                        clamp_case !== e.cc) begin
                        if (qx !== e.x) $error("qx exp %0d got %0d", e.x, qx);
                        if (qy !== e.y) $error("qy exp %0d got %0d", e.y, qy);
                        if (qz !== e.z) $error("qz exp %0d got %0d", e.z, qz);
                        if (clamp_case !== e.cc)
                            $error("clamp_case exp %0d got %0d", e.cc, clamp_case);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= nearest_q.size();
        end
    end

endmodule

// ----- tb/tb_closest_point_on_segment.sv -----
module tb_closest_point_on_segment import cps_pkg::*;;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b1;
    logic o_stall, o_valid;
    logic signed [31:0] i_ax = 0, i_ay = 0, i_az = 0;
    logic signed [31:0] i_bx = 0, i_by = 0, i_bz = 0;
    logic signed [31:0] i_px = 0, i_py = 0, i_pz = 0;
    logic signed [31:0] o_qx, o_qy, o_qz;
    logic [1:0] o_clamp_case;
    int fail_count, pending;

    // drain hold-off must exceed the pipeline latency
    localparam int LATENCY = 39;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1630;

    bit hold_long = 1'b0;
    int idle_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    closest_point_on_segment dut (.*);

    cps_checker chk (
        .i_clk, .i_rst_n,
        .in_valid(i_valid), .in_stall(o_stall),
        .ax(i_ax), .ay(i_ay), .az(i_az), .bx(i_bx), .by(i_by), .bz(i_bz),
        .px(i_px), .py(i_py), .pz(i_pz),
        .out_valid(o_valid), .out_stall(i_stall),
        .qx(o_qx), .qy(o_qy), .qz(o_qz), .clamp_case(o_clamp_case),
        .fail_count, .pending
    );

    // random coordinate: full range, extremes, small near-origin values, or random magnitudes
    function automatic logic signed [31:0] rand_coord();
        unique case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            2:       return $signed($urandom_range(0, 8192)) - 4096;
            default: return $signed($urandom()) >>> $urandom_range(0, 24);
        endcase
    endfunction

    // offer one item and hold it until accepted, after a random idle gap
    task automatic send_item(input logic signed [31:0] v [9]);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_ax, i_ay, i_az} <= {v[0], v[1], v[2]};
        {i_bx, i_by, i_bz} <= {v[3], v[4], v[5]};
        {i_px, i_py, i_pz} <= {v[6], v[7], v[8]};
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_segment(input logic signed [31:0] a0, a1, a2, b0, b1, b2,
                                input logic signed [31:0] p0, p1, p2);
        logic signed [31:0] v [9];
        v = '{a0, a1, a2, b0, b1, b2, p0, p1, p2};
        send_item(v);
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        int wait_cycles;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_long = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    // watchdog on cycles with no accepted item on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] v [9];
        logic signed [31:0] d [3];
        int drain;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degenerate segment, clamps at both ends, interior, extremes
        send_segment(5, 6, 7, 5, 6, 7, 100, -3, 9);
        send_segment(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_segment(0, 0, 0, 32'h10000, 0, 0, -32'sh10000, 0, 0);
        send_segment(0, 0, 0, 32'h10000, 0, 0, 32'h20000, 0, 0);
        send_segment(0, 0, 0, 32'h10000, 0, 0, 32'h10000, 5, 5);
        send_segment(0, 0, 0, 32'h10000, 0, 0, 32'h8000, 7, 7);
        send_segment(0, 0, 0, 3, 0, 0, 1, 0, 0);
        send_segment(0, 0, 0, -3, 0, 0, -1, 0, 0);
        send_segment(32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
        send_segment(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                     32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1, -1, 1);
        send_segment(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, -1, 32'sh80000000,
                     32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send_segment(-1, -1, -1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        send_segment(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -1, -1, -1);
        send_segment(10, 20, 30, -10, -20, -30, 1, 3, 5);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) hold_long = 1'b1;
            if (n == 800) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
            end
            for (int k = 0; k < 9; k++) v[k] = rand_coord();
            // most queries land near the segment so the interior case is common
            if ($urandom_range(0, 2) != 0) begin
                for (int k = 0; k < 3; k++) begin
                    d[k] = $signed($urandom()) >>> $urandom_range(2, 30);
                    v[3 + k] = v[k] >>> 2;
                    v[k] = v[k] >>> 2;
                    v[3 + k] = v[k] + d[k];
                    v[6 + k] = v[k] + (d[k] >>> 1) + ($signed($urandom()) >>> 28);
                end
            end else if ($urandom_range(0, 9) == 0) begin
                for (int k = 0; k < 3; k++) v[3 + k] = v[k];
            end
            send_item(v);
        end
        i_valid <= 1'b0;
        @(posedge i_clk);

        wait (pending == 0);
        drain = 0;
        while (drain < 4 * LATENCY) begin
            @(posedge i_clk);
            drain++;
        end
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
